// ----- hdl/rfr_pkg.sv -----
package rfr_pkg;

   localparam int unsigned ROWS = 6;
   localparam int unsigned COLS = 50;

   localparam int unsigned KIND_W     = 2;
   localparam int unsigned ARG_W      = 6;
   localparam int unsigned LIT_W      = 9;
   localparam int unsigned ROW_BITS_W = 50;

   localparam int unsigned ARG_SPAN = 1 << ARG_W;
   localparam int unsigned RIDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned CIDX_W   = $clog2(COLS);
   localparam int unsigned RSH_W    = $clog2(ROWS + 1);
   localparam int unsigned CSH_W    = $clog2(COLS + 1);
   localparam int unsigned RCNT_W   = $clog2(COLS + 1);
   localparam int unsigned TCNT_W   = $clog2(ROWS * COLS + 1);

   typedef logic [KIND_W-1:0]             kind_type;
   typedef logic [ARG_W-1:0]              arg_type;
   typedef logic [COLS-1:0]               row_type;
   typedef logic [ROWS-1:0][COLS-1:0]     bitmap_type;
   typedef logic [ROWS-1:0]               col_type;
   typedef logic [RCNT_W-1:0]             rcnt_type;
   typedef logic [TCNT_W-1:0]             tcnt_type;
   typedef logic [LIT_W-1:0]              lit_type;
   typedef logic [ROW_BITS_W-1:0]         row_bits_type;
   typedef logic [CIDX_W-1:0]             col_mod_type;
   typedef logic [RIDX_W-1:0]             row_mod_type;
   typedef col_mod_type                   col_mod_tab_type [ARG_SPAN];
   typedef row_mod_type                   row_mod_tab_type [ARG_SPAN];

   localparam kind_type KIND_RECT    = KIND_W'(0);
   localparam kind_type KIND_ROT_ROW = KIND_W'(1);
   localparam kind_type KIND_ROT_COL = KIND_W'(2);
   localparam kind_type KIND_READ    = KIND_W'(3);

   typedef struct packed {
      kind_type kind;
      arg_type  arg_a;
      arg_type  arg_b;
   } cmd_type;

   function automatic col_mod_tab_type make_col_mod();
      col_mod_tab_type t;
      for (int i = 0; i < ARG_SPAN; i++) begin
         t[i] = CIDX_W'(i % COLS);
      end
      return t;
   endfunction

   function automatic row_mod_tab_type make_row_mod();
      row_mod_tab_type t;
      for (int i = 0; i < ARG_SPAN; i++) begin
         t[i] = RIDX_W'(i % ROWS);
      end
      return t;
   endfunction

   localparam col_mod_tab_type COL_MOD = make_col_mod();
   localparam row_mod_tab_type ROW_MOD = make_row_mod();

endpackage

// ----- hdl/rfr_if.sv -----
interface rfr_req_if;
   import rfr_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   arg_type  arg_a;
   arg_type  arg_b;

   modport source (output valid, kind, arg_a, arg_b, input ready);
   modport sink   (input valid, kind, arg_a, arg_b, output ready);
endinterface

interface rfr_rsp_if;
   import rfr_pkg::*;

   logic         valid;
   logic         ready;
   lit_type      lit_count;
   row_bits_type row_bits;

   modport source (output valid, lit_count, row_bits, input ready);
   modport sink   (input valid, lit_count, row_bits, output ready);
endinterface

// ----- hdl/bitmap_rect_fill_rotate_engine_top.sv -----
// channel  | dir | handshake    | word
// ---------+-----+--------------+---------------------------------------
// req_ch   | in  | valid/ready  | kind, arg_a, arg_b
// rsp_ch   | out | valid/ready  | lit_count, row_bits
//
// One word in and one word out per cycle while no result is held on rsp_ch.
// Stages: command register, bitmap update, per-row popcount, total.
// The per-row popcount and total adder set the depth.
// Synchronous reset clears the bitmap and all stage valids.
// A held result stalls the whole pipeline and req_ch.ready.
module bitmap_rect_fill_rotate_engine_top (
   input logic        clock,
   input logic        reset,
   rfr_req_if.sink    req_ch,
   rfr_rsp_if.source  rsp_ch
);
   import rfr_pkg::*;

   logic         adv_w;
   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   cmd_type      cmd1_ff;
   bitmap_type   bitmap_ff, bitmap_in;
   row_bits_type rowbits2_ff, rowbits2_in, rowbits3_ff, rowbits4_ff;
   rcnt_type     cnt3_ff [ROWS];
   lit_type      lit4_ff;

   logic         row_ok_w, col_ok_w;
   logic [RIDX_W-1:0] ridx_w;
   logic [CIDX_W-1:0] cidx_w;
   row_type      sel_row_w, rot_row_w, col_mask_w;
   logic [2*COLS-1:0] row_dbl_w;
   logic [CSH_W-1:0]  row_sh_w;
   col_type      col_w, rot_col_w;
   logic [2*ROWS-1:0] col_dbl_w;
   logic [RSH_W-1:0]  col_sh_w;
   tcnt_type     total_w;

   assign adv_w        = !v4_ff || rsp_ch.ready;
   assign req_ch.ready = adv_w;

   assign row_ok_w  = {1'b0, cmd1_ff.arg_a} < (ARG_W + 1)'(ROWS);
   assign col_ok_w  = {1'b0, cmd1_ff.arg_a} < (ARG_W + 1)'(COLS);
   assign ridx_w    = cmd1_ff.arg_a[RIDX_W-1:0];
   assign cidx_w    = cmd1_ff.arg_a[CIDX_W-1:0];
   assign sel_row_w = bitmap_ff[ridx_w];

   // rotate towards higher column index
   assign row_dbl_w = {sel_row_w, sel_row_w};
   assign row_sh_w  = CSH_W'(COLS) - CSH_W'(COL_MOD[cmd1_ff.arg_b]);
   assign rot_row_w = row_type'(row_dbl_w >> row_sh_w);

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         col_w[r] = bitmap_ff[r][cidx_w];
      end
      for (int j = 0; j < COLS; j++) begin
         col_mask_w[j] = j < int'(cmd1_ff.arg_a);
      end
   end

   assign col_dbl_w = {col_w, col_w};
   assign col_sh_w  = RSH_W'(ROWS) - RSH_W'(ROW_MOD[cmd1_ff.arg_b]);
   assign rot_col_w = col_type'(col_dbl_w >> col_sh_w);

   always_comb begin
      bitmap_in   = bitmap_ff;
      rowbits2_in = '0;
      if (v1_ff) begin
         unique case (cmd1_ff.kind)
            KIND_RECT: begin
               for (int r = 0; r < ROWS; r++) begin
                  if (r < int'(cmd1_ff.arg_b)) begin
                     bitmap_in[r] = bitmap_ff[r] | col_mask_w;
                  end
               end
            end
            KIND_ROT_ROW: begin
               if (row_ok_w) begin
                  bitmap_in[ridx_w] = rot_row_w;
               end
            end
            KIND_ROT_COL: begin
               if (col_ok_w) begin
                  for (int r = 0; r < ROWS; r++) begin
                     bitmap_in[r][cidx_w] = rot_col_w[r];
                  end
               end
            end
            KIND_READ: begin
               if (row_ok_w) begin
                  rowbits2_in = ROW_BITS_W'(sel_row_w);
               end
            end
            default: begin
               bitmap_in = bitmap_ff;
            end
         endcase
      end
   end

   always_comb begin
      total_w = '0;
      for (int r = 0; r < ROWS; r++) begin
         total_w = total_w + TCNT_W'(cnt3_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         bitmap_ff <= '0;
      end else if (adv_w) begin
         v1_ff     <= req_ch.valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         bitmap_ff <= bitmap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         cmd1_ff.kind  <= req_ch.kind;
         cmd1_ff.arg_a <= req_ch.arg_a;
         cmd1_ff.arg_b <= req_ch.arg_b;
         rowbits2_ff   <= rowbits2_in;
         rowbits3_ff   <= rowbits2_ff;
         rowbits4_ff   <= rowbits3_ff;
         lit4_ff       <= LIT_W'(total_w);
         for (int r = 0; r < ROWS; r++) begin
            cnt3_ff[r] <= RCNT_W'($countones(bitmap_ff[r]));
         end
      end
   end

   assign rsp_ch.valid     = v4_ff;
   assign rsp_ch.lit_count = lit4_ff;
   assign rsp_ch.row_bits  = rowbits4_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   a_stall_holds_bitmap: assert property (@(posedge clock) disable iff (reset)
      !adv_w |=> $stable(bitmap_ff))
      else $error("bitmap changed during stall");

   a_bubble_holds_bitmap: assert property (@(posedge clock) disable iff (reset)
      (adv_w && !v1_ff) |=> $stable(bitmap_ff))
      else $error("bitmap changed without a command");

   a_rect_only_sets: assert property (@(posedge clock) disable iff (reset)
      (adv_w && v1_ff && cmd1_ff.kind == KIND_RECT)
      |=> ((bitmap_ff & $past(bitmap_ff)) == $past(bitmap_ff)))
      else $error("rect fill cleared a pixel");

endmodule
